FILE: rtl/core/pfca_pkg.sv
`timescale 1ns / 1ps
// pfca_pkg: types and constants shared by the port flow counter with aging.
// No dependencies.
package pfca_pkg;

    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 31;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_SELECT     = 2'd2;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    localparam logic SEL_UDP = 1'b0;
    localparam logic SEL_SRC = 1'b0;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 31'd1000;

    typedef struct packed {
        logic              op;
        logic              is_udp;
        logic              is_tcp;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [TIME_W-1:0] now_ms;
    } pfca_in_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] active_flows;
        logic                 table_overflowed;
    } pfca_out_t;

    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] last_seen;
    } pfca_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_COMMIT,
        ST_REPORT
    } pfca_state_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic walk;
        logic commit;
        logic report;
    } pfca_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic in_is_sample;
        logic in_match;
        logic item_is_sample;
        logic out_free;
    } pfca_status_t;

endpackage

FILE: rtl/core/pfca_ctrl.sv
`timescale 1ns / 1ps
// pfca_ctrl: sequencer for table clearing, lookup/ageing walks and reporting.
// Depends on pfca_pkg.
module pfca_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  pfca_pkg::pfca_status_t status,
    output pfca_pkg::pfca_cmd_t    cmd
);
    import pfca_pkg::*;

    pfca_state_t state_reg;
    pfca_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.idx_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_valid && (status.in_is_sample || status.in_match))
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.idx_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = status.item_is_sample ? ST_REPORT : ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            ST_REPORT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_REPORT:
            begin
                cmd.report = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && status.idx_last) |=> (state_reg == ST_DRAIN))
        else $error("walk did not end after last entry");

endmodule

FILE: rtl/core/pfca_datapath.sv
`timescale 1ns / 1ps
// pfca_datapath: flow table memory, walk index, hit/free tracking, ageing,
// flow count, overflow flag, configuration and result register. Uses pfca_pkg.
module pfca_datapath #(
    parameter int MAX_FLOWS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pfca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfca_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  pfca_pkg::pfca_in_t                  item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pfca_pkg::pfca_out_t                 result,
    input  pfca_pkg::pfca_cmd_t                 cmd,
    output pfca_pkg::pfca_status_t              status
);
    import pfca_pkg::*;

    localparam int IW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CW = $clog2(MAX_FLOWS + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_FLOWS - 1);

    pfca_entry_t entry_mem [MAX_FLOWS];

    logic [TMO_W-1:0]  timeout_reg;
    logic              proto_sel_reg;
    logic              port_sel_reg;

    logic              sample_reg;
    logic [PORT_W-1:0] port_reg;
    logic [TIME_W-1:0] now_reg;

    logic [IW-1:0]     addr_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              rd_vld_reg;
    pfca_entry_t       rd_data_reg;

    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic              free_reg;
    logic [IW-1:0]     free_idx_reg;

    logic [CW-1:0]     count_reg;
    logic              overflow_reg;

    logic              out_valid_reg;
    pfca_out_t         out_reg;

    logic [TIME_W-1:0] age;
    logic              age_kill;
    logic              port_hit;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    pfca_entry_t       wr_data;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            proto_sel_reg <= SEL_UDP;
            port_sel_reg  <= SEL_SRC;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_MS:      timeout_reg   <= cfg_data[TMO_W-1:0];
                CFG_PROTOCOL_SELECT: proto_sel_reg <= cfg_data[0];
                CFG_PORT_SELECT:     port_sel_reg  <= cfg_data[0];
                default:             timeout_reg   <= timeout_reg;
            endcase
        end
    end

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sample_reg <= (item.op == OP_SAMPLE);
            port_reg   <= port_sel_reg ? item.dst_port : item.src_port;
            now_reg    <= item.now_ms;
        end
    end

    // walk index and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.walk;
            if (cmd.load_item)
                addr_reg <= '0;
            else if (cmd.clear_step || cmd.walk)
                addr_reg <= IW'(addr_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            rd_data_reg <= entry_mem[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
    end

    assign age      = now_reg - rd_data_reg.last_seen;
    assign age_kill = rd_vld_reg && sample_reg && rd_data_reg.valid &&
                      (age >= {1'b0, timeout_reg});
    assign port_hit = rd_data_reg.valid && (rd_data_reg.port == port_reg);

    // lookup tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (rd_vld_reg && !sample_reg)
        begin
            if (port_hit)
                hit_reg <= 1'b1;
            if (!rd_data_reg.valid && !free_reg)
                free_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && !sample_reg)
        begin
            if (port_hit)
                hit_idx_reg <= rd_idx_reg;
            if (!rd_data_reg.valid && !free_reg)
                free_idx_reg <= rd_idx_reg;
        end
    end

    // table write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        priority if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.commit && (hit_reg || free_reg))
        begin
            wr_en   = 1'b1;
            wr_addr = hit_reg ? hit_idx_reg : free_idx_reg;
            wr_data = '{valid: 1'b1, port: port_reg, last_seen: now_reg};
        end
        else if (age_kill)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
            wr_data = '{valid: 1'b0, port: rd_data_reg.port,
                        last_seen: rd_data_reg.last_seen};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= wr_data;
    end

    // flow count, overflow flag, result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (age_kill && (count_reg != '0))
                count_reg <= CW'(count_reg - 1'b1);
            else if (cmd.commit && !hit_reg && free_reg)
                count_reg <= CW'(count_reg + 1'b1);

            if (cmd.commit && !hit_reg && !free_reg)
                overflow_reg <= 1'b1;
            else if (cmd.report)
                overflow_reg <= 1'b0;

            if (cmd.report)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            out_reg.active_flows     <= CNT_OUT_W'(count_reg);
            out_reg.table_overflowed <= overflow_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign status.idx_last       = (addr_reg == IDX_LAST);
    assign status.in_is_sample   = (item.op == OP_SAMPLE);
    assign status.in_match       = proto_sel_reg ? item.is_tcp : item.is_udp;
    assign status.item_is_sample = sample_reg;
    assign status.out_free       = !out_valid_reg || result_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_FLOWS))
        else $error("flow count above table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> (result_valid && result.table_overflowed == $past(overflow_reg)))
        else $error("report did not load result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_reg && !free_reg) |=> overflow_reg)
        else $error("dropped flow not flagged");

endmodule

FILE: rtl/core/port_flow_counter_with_aging_unit.sv
`timescale 1ns / 1ps
// port_flow_counter_with_aging_unit: top level of the port flow table.
// Instantiates pfca_ctrl and pfca_datapath; uses pfca_pkg.
//
// Usage:
//   item channel (item_valid/item_ready/item): observe or sample transaction.
//   An observe of the selected protocol looks up the selected port in a
//   table of MAX_FLOWS entries, refreshes or inserts it, or sets the sticky
//   overflow flag when the table is full. Other observes are dropped at once.
//   A sample ages out entries whose age is at or beyond timeout_ms, then
//   returns one transaction on result (result_valid/result_ready) with the
//   remaining count and the overflow flag, which it clears.
//   Config: cfg_we, cfg_index, cfg_data; write only while idle.
//   Timing: one table walk reads one entry per cycle from a single-port
//   read / single-port write memory. A matching observe or a sample holds
//   item_ready low after acceptance through the walk, a drain state and a
//   commit or report state; the sample result is registered in the report
//   state, which waits until the output register is free.
//   Reset: a clearing pass over all MAX_FLOWS entries empties the table;
//   item_ready stays low until it ends. Config writes are taken throughout.
//   Stall: a result waits in the output register; a second sample only
//   waits for that register at its end.
module port_flow_counter_with_aging_unit #(
    parameter int MAX_FLOWS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfca_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  pfca_pkg::pfca_in_t              item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output pfca_pkg::pfca_out_t             result
);
    import pfca_pkg::*;

    pfca_cmd_t    cmd;
    pfca_status_t status;

    pfca_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    pfca_datapath #(
        .MAX_FLOWS (MAX_FLOWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for port_flow_counter_with_aging_unit, with a
// directed table, random phases and a flow table predictor. Depends on pfca_pkg.
module testbench;
    import pfca_pkg::*;

    localparam int MAX_FLOWS = 64;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES = MAX_FLOWS + 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic SEL_TCP = ~SEL_UDP;
    localparam logic SEL_DST = ~SEL_SRC;
    localparam logic [TMO_W-1:0] TMO_MAX = '1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        pfca_in_t  stim;
        logic      checked;
        pfca_out_t want;
    } dir_row_t;

    typedef struct packed {
        logic [TMO_W-1:0] tmo;
        logic             proto;
        logic             keysel;
        idle_mode_t       idle;
        logic [7:0]       pool_span;
        logic [6:0]       sample_pct;
    } phase_t;

    localparam int DIR_N = 15;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{'{OP_SAMPLE,  1'b0, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000}, 1'b1, '{7'd0, 1'b0}},
        '{'{OP_OBSERVE, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 32'h0000_0000}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_OBSERVE, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 32'h0000_0000}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_OBSERVE, 1'b0, 1'b1, 16'h1234, 16'h1234, 32'h0000_0005}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_OBSERVE, 1'b1, 1'b1, 16'h0000, 16'h5555, 32'h0000_000A}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_OBSERVE, 1'b0, 1'b0, 16'hAAAA, 16'h5555, 32'h0000_000A}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_SAMPLE,  1'b0, 1'b0, 16'h0000, 16'h0000, 32'h0000_03E7}, 1'b1, '{7'd2, 1'b0}},
        '{'{OP_SAMPLE,  1'b0, 1'b0, 16'h0000, 16'h0000, 32'h0000_03E8}, 1'b1, '{7'd1, 1'b0}},
        '{'{OP_OBSERVE, 1'b1, 1'b0, 16'h0005, 16'h0000, 32'hFFFF_FFF0}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_SAMPLE,  1'b0, 1'b0, 16'h0000, 16'h0000, 32'h0000_0010}, 1'b1, '{7'd2, 1'b0}},
        '{'{OP_SAMPLE,  1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{7'd1, 1'b0}},
        '{'{OP_OBSERVE, 1'b1, 1'b0, 16'h8001, 16'h7FFE, 32'h7FFF_FFFF}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_OBSERVE, 1'b1, 1'b1, 16'h7FFE, 16'h8001, 32'h8000_0000}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_SAMPLE,  1'b0, 1'b1, 16'h0000, 16'h0000, 32'h8000_0100}, 1'b0, '{7'd0, 1'b0}},
        '{'{OP_SAMPLE,  1'b1, 1'b0, 16'h0000, 16'h0000, 32'h8000_0400}, 1'b1, '{7'd0, 1'b0}}
    };

    localparam int PHASE_N = 8;
    localparam phase_t PHASES [PHASE_N] = '{
        '{31'd1000,       SEL_UDP, SEL_SRC, IDLE_NONE,     8'd96,  7'd5},
        '{31'd0,          SEL_TCP, SEL_DST, IDLE_SENDER,   8'd16,  7'd15},
        '{TMO_MAX,        SEL_UDP, SEL_DST, IDLE_RECEIVER, 8'd120, 7'd3},
        '{31'd50,         SEL_TCP, SEL_SRC, IDLE_BOTH,     8'd80,  7'd4},
        '{31'd4321,       SEL_UDP, SEL_SRC, IDLE_NONE,     8'd70,  7'd6},
        '{31'h7FFF_FFFE,  SEL_TCP, SEL_DST, IDLE_SENDER,   8'd200, 7'd8},
        '{31'd1,          SEL_TCP, SEL_SRC, IDLE_BOTH,     8'd64,  7'd10},
        '{31'd2000,       SEL_UDP, SEL_DST, IDLE_RECEIVER, 8'd100, 7'd5}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_ready;
    pfca_in_t              item;
    logic                  result_valid;
    logic                  result_ready;
    pfca_out_t             result;

    // flow table predictor
    logic               flow_live [MAX_FLOWS];
    logic [PORT_W-1:0]  flow_key  [MAX_FLOWS];
    logic [TIME_W-1:0]  flow_seen [MAX_FLOWS];
    int                 flow_total;
    logic               dropped_flag;
    logic [TMO_W-1:0]   age_limit;
    logic               count_tcp;
    logic               key_by_dst;
    pfca_out_t          reports_due [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;

    port_flow_counter_with_aging_unit #(
        .MAX_FLOWS(MAX_FLOWS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void track_flow_item(input pfca_in_t it);
        logic [PORT_W-1:0] key;
        logic [TIME_W-1:0] age;
        int                free_slot;
        logic              hit;
        pfca_out_t         rep;
        if (it.op == OP_OBSERVE)
        begin
            if ((count_tcp == SEL_TCP) ? it.is_tcp : it.is_udp)
            begin
                key = (key_by_dst == SEL_DST) ? it.dst_port : it.src_port;
                free_slot = -1;
                hit = 1'b0;
                for (int i = 0; i < MAX_FLOWS; i++)
                begin
                    if (flow_live[i])
                    begin
                        if (!hit && flow_key[i] == key)
                        begin
                            flow_seen[i] = it.now_ms;
                            hit = 1'b1;
                        end
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
                if (!hit)
                begin
                    if (free_slot >= 0)
                    begin
                        flow_live[free_slot] = 1'b1;
                        flow_key[free_slot] = key;
                        flow_seen[free_slot] = it.now_ms;
                        flow_total++;
                    end
                    else
                        dropped_flag = 1'b1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < MAX_FLOWS; i++)
            begin
                if (flow_live[i])
                begin
                    age = it.now_ms - flow_seen[i];
                    if (age >= {1'b0, age_limit})
                    begin
                        flow_live[i] = 1'b0;
                        if (flow_total > 0)
                            flow_total--;
                    end
                end
            end
            rep.active_flows = 7'(flow_total);
            rep.table_overflowed = dropped_flag;
            reports_due.push_back(rep);
            dropped_flag = 1'b0;
        end
    endfunction

    task automatic program_registers(input logic [TMO_W-1:0] tmo, input logic proto,
                                     input logic keysel);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TIMEOUT_MS;
        cfg_data <= tmo;
        @(posedge clk);
        cfg_index <= CFG_PROTOCOL_SELECT;
        cfg_data <= {30'($urandom), proto};
        @(posedge clk);
        cfg_index <= CFG_PORT_SELECT;
        cfg_data <= {30'($urandom), keysel};
        @(posedge clk);
        cfg_index <= CFG_UNMAPPED;
        cfg_data <= 31'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        age_limit = tmo;
        count_tcp = proto;
        key_by_dst = keysel;
    endtask

    task automatic send_item(input pfca_in_t it);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        track_flow_item(it);
    endtask

    // sender held off until every outstanding report is back
    task automatic drain_reports();
        item_valid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle_table();
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_side
        pfca_out_t want;
        if (rst_n && result_valid === 1'b1 && result_ready)
        begin
            if (reports_due.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected report transaction: flows %0d overflow %0b",
                             result.active_flows, result.table_overflowed);
                mismatch_count++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (result.active_flows !== want.active_flows
                    || result.table_overflowed !== want.table_overflowed)
                begin
                    if (mismatch_count < 10)
                        $display("report mismatch: expected flows %0d overflow %0b, got flows %0d overflow %0b",
                                 want.active_flows, want.table_overflowed,
                                 result.active_flows, result.table_overflowed);
                    mismatch_count++;
                end
            end
        end
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin : stimulus
        pfca_in_t          it;
        phase_t            ph;
        logic [TIME_W-1:0] clock_ms;
        logic [PORT_W-1:0] pool_base;
        logic [PORT_W-1:0] key;
        int unsigned       step_max;
        int                done_items;
        int                roll;
        int                pick;
        int                slot;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        flow_total = 0;
        dropped_flag = 1'b0;
        age_limit = TIMEOUT_RESET;
        count_tcp = SEL_UDP;
        key_by_dst = SEL_SRC;
        for (int i = 0; i < MAX_FLOWS; i++)
        begin
            flow_live[i] = 1'b0;
            flow_key[i] = '0;
            flow_seen[i] = '0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        program_registers(TIMEOUT_RESET, SEL_UDP, SEL_SRC);

        for (int r = 0; r < DIR_N; r++)
        begin
            send_item(DIR_ROWS[r].stim);
            if (DIR_ROWS[r].checked)
                reports_due[$] = DIR_ROWS[r].want;
        end
        settle_table();

        for (int p = 0; p < PHASE_N; p++)
        begin
            ph = PHASES[p];
            unique case (ph.idle)
                IDLE_SENDER:   begin send_idle_pct = 83; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                IDLE_BOTH:     begin send_idle_pct = 18; recv_stall_pct = 18; end
                default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            program_registers(ph.tmo, ph.proto, ph.keysel);
            pool_base = 16'($urandom);
            clock_ms = $urandom;
            step_max = (int'(ph.tmo) >> 4) + 2;
            done_items = 0;
            while (done_items < ITEMS_PER_PHASE)
            begin
                it = '0;
                it.src_port = 16'($urandom);
                it.dst_port = 16'($urandom);
                clock_ms = clock_ms + $urandom_range(0, step_max);
                it.now_ms = clock_ms;
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    // wrong protocol, dropped by the block
                    it.op = OP_OBSERVE;
                    if (count_tcp == SEL_TCP)
                        it.is_udp = 1'($urandom_range(0, 1));
                    else
                        it.is_tcp = 1'($urandom_range(0, 1));
                end
                else if (roll < 8 + int'(ph.sample_pct))
                begin
                    it.op = OP_SAMPLE;
                    it.is_udp = 1'($urandom_range(0, 1));
                    it.is_tcp = 1'($urandom_range(0, 1));
                    pick = $urandom_range(0, 99);
                    if (pick < 35 && flow_total != 0)
                    begin
                        // land on, just before or just after a flow's ageing edge
                        slot = $urandom_range(0, MAX_FLOWS - 1);
                        while (!flow_live[slot])
                            slot = (slot + 1) % MAX_FLOWS;
                        it.now_ms = flow_seen[slot] + {1'b0, age_limit}
                                    + 32'($urandom_range(0, 2)) - 32'd1;
                    end
                    else if (pick < 42)
                        it.now_ms = $urandom;
                    clock_ms = it.now_ms;
                    done_items++;
                end
                else
                begin
                    it.op = OP_OBSERVE;
                    if (count_tcp == SEL_TCP)
                    begin
                        it.is_tcp = 1'b1;
                        it.is_udp = 1'($urandom_range(0, 1));
                    end
                    else
                    begin
                        it.is_udp = 1'b1;
                        it.is_tcp = 1'($urandom_range(0, 1));
                    end
                    if ($urandom_range(0, 19) == 0)
                        key = 16'($urandom);
                    else
                        key = pool_base ^ 16'($urandom_range(0, int'(ph.pool_span) - 1));
                    if (key_by_dst == SEL_DST)
                        it.dst_port = key;
                    else
                        it.src_port = key;
                    done_items++;
                end
                if ($urandom_range(0, 149) == 0)
                    drain_reports();
                send_item(it);
            end
            settle_table();
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
